[rtl/quaternion_to_euler_angles_macros.svh]
// Assertion macros for the quaternion to Euler angle block.
// They expect signals named clk and arst_n in the scope of use.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define Q2E_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/q2e_pkg.sv]
// Shared constants, types and functions of the quaternion to Euler angle block.
// No dependencies.
package q2e_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int CORDIC_STEPS    = 24;
	localparam int ANGLE_SHIFT     = 24 - ANGLE_FRAC_BITS;

	localparam int Q_W     = 32;           // saturated Q30 part
	localparam int T_W     = 34;           // angle operands
	localparam int RAD_W   = 61;           // radicand up to 2^60
	localparam int ROOT_W  = 31;           // root up to 2^30
	localparam int REM_W   = ROOT_W + 3;
	localparam int SIDE_W  = 5 * T_W + 1;
	localparam int XW      = T_W + 18;     // CORDIC x and y
	localparam int ZW      = 34;           // angle in degrees * 2^24
	localparam int LANES   = 3;

	localparam logic signed [Q_W-1:0]   ONE_Q30   = 32'sd1073741824;
	localparam logic signed [T_W-1:0]   ONE_Q30_T = 34'sd1073741824;
	localparam logic [62:0]             ONE_Q60   = 63'd1 << 60;
	localparam logic signed [ZW-1:0]    DEG180    = 34'sd180 <<< 24;
	localparam logic [63:0]             DEG_PER_RAD_Q32 = 64'd246083499208;

	localparam logic signed [35:0] ANGLE_HALF = (36'sd1 <<< ANGLE_SHIFT) >>> 1;
	localparam logic signed [35:0] ROLL_LIM   = 36'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic signed [35:0] PITCH_LIM  = 36'sd90 <<< ANGLE_FRAC_BITS;
	localparam logic signed [16:0] ROLL_LIM_O  = ROLL_LIM[16:0];
	localparam logic signed [15:0] PITCH_LIM_O = PITCH_LIM[15:0];

	typedef logic signed [Q_W-1:0] q30_t;
	typedef logic signed [T_W-1:0] tval_t;
	typedef logic signed [ZW-1:0]  ang_t;

	// atan(2^-i) in degrees * 2^24
	function automatic ang_t atan_step(input int i);
		logic [63:0] v;
		case (i)
			0:       v = 64'd754974720;
			1:       v = 64'd445687602;
			2:       v = 64'd235489088;
			3:       v = 64'd119537938;
			4:       v = 64'd60000934;
			5:       v = 64'd30029717;
			6:       v = 64'd15018523;
			7:       v = 64'd7509720;
			8:       v = 64'd3754917;
			9:       v = 64'd1877466;
			10:      v = 64'd938734;
			11:      v = 64'd469367;
			default: v = DEG_PER_RAD_Q32 >> (i + 8);
		endcase
		return ang_t'(v);
	endfunction

	function automatic q30_t sat_q30(input q30_t v);
		if (v > ONE_Q30)
			return ONE_Q30;
		if (v < -ONE_Q30)
			return -ONE_Q30;
		return v;
	endfunction

	// Rounds half up to the output fraction and clamps to +-lim.
	function automatic logic signed [35:0] deg_out(input ang_t z,
			input logic signed [35:0] lim);
		logic signed [35:0] v;
		v = (36'(z) + ANGLE_HALF) >>> ANGLE_SHIFT;
		if (v > lim)
			v = lim;
		else if (v < -lim)
			v = -lim;
		return v;
	endfunction

endpackage

[rtl/q2e_ifs.sv]
// Handshake interfaces for the quaternion input and the angle output.
// Depends on q2e_pkg.
interface q2e_in_if import q2e_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              quat_present;
	logic signed [31:0] quat_x_part;
	logic signed [31:0] quat_y_part;
	logic signed [31:0] quat_z_part;

	modport source(output valid, quat_present, quat_x_part, quat_y_part, quat_z_part,
		input ready);
	modport sink(input valid, quat_present, quat_x_part, quat_y_part, quat_z_part,
		output ready);
endinterface

interface q2e_out_if import q2e_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [16:0] roll_deg;
	logic signed [15:0] pitch_deg;
	logic signed [16:0] yaw_deg;
	logic               norm_overflow;

	modport source(output valid, roll_deg, pitch_deg, yaw_deg, norm_overflow,
		input ready);
	modport sink(input valid, roll_deg, pitch_deg, yaw_deg, norm_overflow,
		output ready);
endinterface

[rtl/q2e_isqrt.sv]
// Pipelined floor square root, one root bit per stage, with side data.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [RAD_W-1:0]  rad_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [ROOT_W-1:0] root_out,
	output logic [SIDE_W-1:0] side_out
);

	localparam int N = ROOT_W;

	logic                vld_s  [N+1];
	logic [REM_W-1:0]    rem_s  [N+1];
	logic [ROOT_W-1:0]   root_s [N+1];
	logic [2*N-1:0]      bits_s [N+1];
	logic [SIDE_W-1:0]   side_s [N+1];

	assign vld_s[0]  = vld_in;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign bits_s[0] = (2*N)'(rad_in);
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [REM_W-1:0] rem_cat;
		logic [REM_W-1:0] trial;
		logic             take;

		always_comb begin
			rem_cat = {rem_s[k][REM_W-3:0], bits_s[k][2*N-1 -: 2]};
			trial   = REM_W'({root_s[k], 2'b01});
			take    = rem_cat >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_cat - trial : rem_cat;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], take};
				bits_s[k+1] <= {bits_s[k][2*N-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out  = vld_s[N];
	assign root_out = root_s[N];
	assign side_out = side_s[N];

endmodule

[rtl/q2e_cordic3.sv]
// Three-lane pipelined CORDIC vectoring unit giving atan2(y, x) in degrees * 2^24.
// Depends on q2e_pkg.
module q2e_cordic3 import q2e_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  logic  side_in,
	input  tval_t y_in [LANES],
	input  tval_t x_in [LANES],
	output logic  vld_out,
	output logic  side_out,
	output ang_t  z_out [LANES]
);

	localparam int N = CORDIC_STEPS;

	logic                 vld_s  [N+1];
	logic                 side_s [N+1];
	logic signed [XW-1:0] x_s    [LANES][N+1];
	logic signed [XW-1:0] y_s    [LANES][N+1];
	ang_t                 z_s    [LANES][N+1];
	logic                 zero_s [LANES][N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [XW-1:0] xe, ye;

		always_comb begin
			xe = {{(XW-T_W-16){x_in[l][T_W-1]}}, x_in[l], 16'b0};
			ye = {{(XW-T_W-16){y_in[l][T_W-1]}}, y_in[l], 16'b0};
		end

		// A negative x is folded into the right half plane with a 180 degree offset.
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[l][0] <= (x_in[l] == '0) && (y_in[l] == '0);
				if (x_in[l] < 0) begin
					x_s[l][0] <= -xe;
					y_s[l][0] <= -ye;
					z_s[l][0] <= (y_in[l] >= 0) ? DEG180 : -DEG180;
				end else begin
					x_s[l][0] <= xe;
					y_s[l][0] <= ye;
					z_s[l][0] <= '0;
				end
			end
		end

		for (genvar k = 0; k < N; k++) begin : g_step
			localparam ang_t ATAN_K = atan_step(k);
			logic signed [XW-1:0] dx, dy;

			always_comb begin
				dx = y_s[l][k] >>> k;
				dy = x_s[l][k] >>> k;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					zero_s[l][k+1] <= zero_s[l][k];
					if (y_s[l][k] > 0) begin
						x_s[l][k+1] <= x_s[l][k] + dx;
						y_s[l][k+1] <= y_s[l][k] - dy;
						z_s[l][k+1] <= z_s[l][k] + ATAN_K;
					end else begin
						x_s[l][k+1] <= x_s[l][k] - dx;
						y_s[l][k+1] <= y_s[l][k] + dy;
						z_s[l][k+1] <= z_s[l][k] - ATAN_K;
					end
				end
			end
		end

		assign z_out[l] = zero_s[l][N] ? '0 : z_s[l][N];
	end

	for (genvar k = 0; k < N; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out  = vld_s[N];
	assign side_out = side_s[N];

endmodule

[rtl/quaternion_to_euler_angles.sv]
// Quaternion to roll, pitch and yaw through the two bit-per-stage square roots and
// the CORDIC stages. Throughput one item per cycle; an output stall freezes the
// whole pipeline. Items without a quaternion are taken and give no result.
// Reset clears the valid bits only. Depends on q2e_pkg, q2e_ifs, q2e_isqrt, q2e_cordic3.
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles import q2e_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	q2e_in_if.sink    quat_in,
	q2e_out_if.source euler_out
);

	logic en;
	assign en = !euler_out.valid || euler_out.ready;
	assign quat_in.ready = en;

	// Stage 1: saturate the parts.
	logic vld_s1;
	q30_t p1_s1, p2_s1, p3_s1;

	// Stage 2: squares.
	logic vld_s2;
	q30_t p1_s2, p2_s2, p3_s2;
	logic [RAD_W-1:0] sq1_s2, sq2_s2, sq3_s2;

	// Stage 3: norm, overflow and the two diagonal terms.
	logic vld_s3, over_s3;
	q30_t p1_s3, p2_s3, p3_s3;
	logic [RAD_W-1:0] rad_s3;
	tval_t t1_s3, t4_s3;

	logic [62:0] norm, sxy, syz;
	logic [62:0] rad_full;
	logic signed [Q_W-1:0] p1_sq, p2_sq, p3_sq;
	logic signed [63:0] sq1_f, sq2_f, sq3_f;

	always_comb begin
		sq1_f = 64'(p1_s1) * 64'(p1_s1);
		sq2_f = 64'(p2_s1) * 64'(p2_s1);
		sq3_f = 64'(p3_s1) * 64'(p3_s1);
		p1_sq = p1_s2;
		p2_sq = p2_s2;
		p3_sq = p3_s2;
		norm  = 63'(sq1_s2) + 63'(sq2_s2) + 63'(sq3_s2);
		sxy   = 63'(sq2_s2) + 63'(sq1_s2);
		syz   = 63'(sq1_s2) + 63'(sq3_s2);
		rad_full = ONE_Q60 - norm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= quat_in.valid && quat_in.quat_present;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= sat_q30(quat_in.quat_x_part);
			p2_s1  <= sat_q30(quat_in.quat_y_part);
			p3_s1  <= sat_q30(quat_in.quat_z_part);
			p1_s2  <= p1_s1;
			p2_s2  <= p2_s1;
			p3_s2  <= p3_s1;
			sq1_s2 <= sq1_f[RAD_W-1:0];
			sq2_s2 <= sq2_f[RAD_W-1:0];
			sq3_s2 <= sq3_f[RAD_W-1:0];
			p1_s3  <= p1_sq;
			p2_s3  <= p2_sq;
			p3_s3  <= p3_sq;
			over_s3 <= norm > ONE_Q60;
			rad_s3  <= (norm > ONE_Q60) ? '0 : rad_full[RAD_W-1:0];
			t1_s3   <= ONE_Q30_T - tval_t'({1'b0, sxy[61:29]});
			t4_s3   <= ONE_Q30_T - tval_t'({1'b0, syz[61:29]});
		end
	end

	// Scalar part w.
	logic              vld_w;
	logic [ROOT_W-1:0] w_root;
	logic [SIDE_W-1:0] side_w;

	q2e_isqrt u_sqrt_w (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s3),
		.rad_in  (rad_s3),
		.side_in ({6'b0, t1_s3, t4_s3, p1_s3, p2_s3, p3_s3, over_s3}),
		.vld_out (vld_w),
		.root_out(w_root),
		.side_out(side_w)
	);

	tval_t t1_w, t4_w;
	q30_t  ax, ay, az, aw;
	logic  over_w;

	// Axis remap: x is the second part, y the first and z minus the third.
	always_comb begin
		t1_w   = side_w[2*T_W+3*Q_W:T_W+3*Q_W+1];
		t4_w   = side_w[T_W+3*Q_W:3*Q_W+1];
		ay     = side_w[3*Q_W:2*Q_W+1];
		ax     = side_w[2*Q_W:Q_W+1];
		az     = -q30_t'(side_w[Q_W:1]);
		over_w = side_w[0];
		aw     = q30_t'({1'b0, w_root});
	end

	// Stage 4: cross products.
	logic vld_s4, over_s4;
	tval_t t1_s4, t4_s4;
	logic signed [63:0] wx_s4, yz_s4, wy_s4, xz_s4, wz_s4, xy_s4;

	// Stage 5: the three mixed terms.
	logic vld_s5, over_s5;
	tval_t t0_s5, t1_s5, t2_s5, t3_s5, t4_s5;
	logic signed [63:0] s0, s2, s3, s2_sh;

	always_comb begin
		s0    = (wx_s4 + yz_s4) >>> 29;
		s2_sh = (wy_s4 - xz_s4) >>> 29;
		s3    = (wz_s4 + xy_s4) >>> 29;
		if (s2_sh > 64'(ONE_Q30))
			s2 = 64'(ONE_Q30);
		else if (s2_sh < -64'(ONE_Q30))
			s2 = -64'(ONE_Q30);
		else
			s2 = s2_sh;
	end

	// Stage 6: square of the pitch term. Stage 7: radicand for the cosine.
	logic vld_s6, over_s6, vld_s7, over_s7;
	tval_t t0_s6, t1_s6, t2_s6, t3_s6, t4_s6;
	tval_t t0_s7, t1_s7, t2_s7, t3_s7, t4_s7;
	logic [RAD_W-1:0] t2sq_s6, rad2_s7;
	logic signed [63:0] t2sq_f;
	logic [62:0] rad2_full;

	always_comb begin
		t2sq_f    = 64'(t2_s5) * 64'(t2_s5);
		rad2_full = ONE_Q60 - 63'(t2sq_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_w;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s4   <= 64'(aw) * 64'(ax);
			yz_s4   <= 64'(ay) * 64'(az);
			wy_s4   <= 64'(aw) * 64'(ay);
			xz_s4   <= 64'(ax) * 64'(az);
			wz_s4   <= 64'(aw) * 64'(az);
			xy_s4   <= 64'(ax) * 64'(ay);
			t1_s4   <= t1_w;
			t4_s4   <= t4_w;
			over_s4 <= over_w;

			t0_s5   <= s0[T_W-1:0];
			t2_s5   <= s2[T_W-1:0];
			t3_s5   <= s3[T_W-1:0];
			t1_s5   <= t1_s4;
			t4_s5   <= t4_s4;
			over_s5 <= over_s4;

			t2sq_s6 <= t2sq_f[RAD_W-1:0];
			t0_s6   <= t0_s5;
			t1_s6   <= t1_s5;
			t2_s6   <= t2_s5;
			t3_s6   <= t3_s5;
			t4_s6   <= t4_s5;
			over_s6 <= over_s5;

			rad2_s7 <= rad2_full[RAD_W-1:0];
			t0_s7   <= t0_s6;
			t1_s7   <= t1_s6;
			t2_s7   <= t2_s6;
			t3_s7   <= t3_s6;
			t4_s7   <= t4_s6;
			over_s7 <= over_s6;
		end
	end

	// Cosine of pitch, so that asin becomes an atan2.
	logic              vld_c;
	logic [ROOT_W-1:0] c_root;
	logic [SIDE_W-1:0] side_c;

	q2e_isqrt u_sqrt_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s7),
		.rad_in  (rad2_s7),
		.side_in ({t0_s7, t1_s7, t2_s7, t3_s7, t4_s7, over_s7}),
		.vld_out (vld_c),
		.root_out(c_root),
		.side_out(side_c)
	);

	tval_t ys [LANES];
	tval_t xs [LANES];

	always_comb begin
		ys[0] = side_c[5*T_W:4*T_W+1];
		xs[0] = side_c[4*T_W:3*T_W+1];
		ys[1] = side_c[3*T_W:2*T_W+1];
		xs[1] = tval_t'({1'b0, c_root});
		ys[2] = side_c[2*T_W:T_W+1];
		xs[2] = side_c[T_W:1];
	end

	logic cord_vld, cord_over;
	ang_t zs [LANES];

	q2e_cordic3 u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_c),
		.side_in (side_c[0]),
		.y_in    (ys),
		.x_in    (xs),
		.vld_out (cord_vld),
		.side_out(cord_over),
		.z_out   (zs)
	);

	// Output register.
	logic               out_vld_q, over_q;
	logic signed [35:0] roll_full, pitch_full, yaw_full;
	logic signed [16:0] roll_q, yaw_q;
	logic signed [15:0] pitch_q;

	always_comb begin
		roll_full  = deg_out(zs[0], ROLL_LIM);
		pitch_full = deg_out(zs[1], PITCH_LIM);
		yaw_full   = deg_out(zs[2], ROLL_LIM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= cord_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_full[16:0];
			pitch_q <= pitch_full[15:0];
			yaw_q   <= yaw_full[16:0];
			over_q  <= cord_over;
		end
	end

	assign euler_out.valid         = out_vld_q;
	assign euler_out.roll_deg      = roll_q;
	assign euler_out.pitch_deg     = pitch_q;
	assign euler_out.yaw_deg       = yaw_q;
	assign euler_out.norm_overflow = over_q;

	`Q2E_ASSERT_IMP(a_ready_when_empty, !euler_out.valid, quat_in.ready, "input blocked with empty output")
	`Q2E_ASSERT_IMP(a_pitch_range, euler_out.valid, (euler_out.pitch_deg <= PITCH_LIM_O) && (euler_out.pitch_deg >= -PITCH_LIM_O), "pitch out of range")
	`Q2E_ASSERT_IMP(a_roll_range, euler_out.valid, (euler_out.roll_deg <= ROLL_LIM_O) && (euler_out.roll_deg >= -ROLL_LIM_O), "roll out of range")
	`Q2E_ASSERT_NXT(a_no_phantom, !euler_out.valid && !cord_vld, !euler_out.valid, "result without a pipeline item")

endmodule
